FILE: design/m4inv_pkg.sv
package m4inv_pkg;

  localparam int MATRIX_ENTRIES = 16;
  localparam int FRAC_BITS      = 16;
  localparam int EW             = 32;
  localparam int AW             = $clog2(MATRIX_ENTRIES);
  localparam int COFW           = 3 * EW + 1;
  localparam int DETW           = COFW + EW + 2;
  localparam int MW             = DETW;
  localparam int DMW            = DETW - 1;
  localparam int NUMW           = COFW - 1 + 2 * FRAC_BITS;
  localparam int NCW            = $clog2(NUMW);
  localparam int TDW            = 40;
  localparam int TUW            = 2;

  typedef enum logic [3:0] {
    ST_LOAD, ST_TA, ST_TB, ST_TY, ST_MUL1, ST_MUL2,
    ST_DA, ST_DB, ST_MUL3, ST_CHK, ST_VA, ST_VB, ST_DIV, ST_OUT
  } state_e;

  // {add, a, b, c}: +/- m[a]*m[b]*m[c]
  localparam logic [12:0] COF_TERMS [16][6] = '{
    '{{1'b1,4'd5,4'd10,4'd15},{1'b0,4'd5,4'd11,4'd14},{1'b0,4'd9,4'd6,4'd15},
      {1'b1,4'd9,4'd7,4'd14},{1'b1,4'd13,4'd6,4'd11},{1'b0,4'd13,4'd7,4'd10}},
    '{{1'b0,4'd1,4'd10,4'd15},{1'b1,4'd1,4'd11,4'd14},{1'b1,4'd9,4'd2,4'd15},
      {1'b0,4'd9,4'd3,4'd14},{1'b0,4'd13,4'd2,4'd11},{1'b1,4'd13,4'd3,4'd10}},
    '{{1'b1,4'd1,4'd6,4'd15},{1'b0,4'd1,4'd7,4'd14},{1'b0,4'd5,4'd2,4'd15},
      {1'b1,4'd5,4'd3,4'd14},{1'b1,4'd13,4'd2,4'd7},{1'b0,4'd13,4'd3,4'd6}},
    '{{1'b0,4'd1,4'd6,4'd11},{1'b1,4'd1,4'd7,4'd10},{1'b1,4'd5,4'd2,4'd11},
      {1'b0,4'd5,4'd3,4'd10},{1'b0,4'd9,4'd2,4'd7},{1'b1,4'd9,4'd3,4'd6}},
    '{{1'b0,4'd4,4'd10,4'd15},{1'b1,4'd4,4'd11,4'd14},{1'b1,4'd8,4'd6,4'd15},
      {1'b0,4'd8,4'd7,4'd14},{1'b0,4'd12,4'd6,4'd11},{1'b1,4'd12,4'd7,4'd10}},
    '{{1'b1,4'd0,4'd10,4'd15},{1'b0,4'd0,4'd11,4'd14},{1'b0,4'd8,4'd2,4'd15},
      {1'b1,4'd8,4'd3,4'd14},{1'b1,4'd12,4'd2,4'd11},{1'b0,4'd12,4'd3,4'd10}},
    '{{1'b0,4'd0,4'd6,4'd15},{1'b1,4'd0,4'd7,4'd14},{1'b1,4'd4,4'd2,4'd15},
      {1'b0,4'd4,4'd3,4'd14},{1'b0,4'd12,4'd2,4'd7},{1'b1,4'd12,4'd3,4'd6}},
    '{{1'b1,4'd0,4'd6,4'd11},{1'b0,4'd0,4'd7,4'd10},{1'b0,4'd4,4'd2,4'd11},
      {1'b1,4'd4,4'd3,4'd10},{1'b1,4'd8,4'd2,4'd7},{1'b0,4'd8,4'd3,4'd6}},
    '{{1'b1,4'd4,4'd9,4'd15},{1'b0,4'd4,4'd11,4'd13},{1'b0,4'd8,4'd5,4'd15},
      {1'b1,4'd8,4'd7,4'd13},{1'b1,4'd12,4'd5,4'd11},{1'b0,4'd12,4'd7,4'd9}},
    '{{1'b0,4'd0,4'd9,4'd15},{1'b1,4'd0,4'd11,4'd13},{1'b1,4'd8,4'd1,4'd15},
      {1'b0,4'd8,4'd3,4'd13},{1'b0,4'd12,4'd1,4'd11},{1'b1,4'd12,4'd3,4'd9}},
    '{{1'b1,4'd0,4'd5,4'd15},{1'b0,4'd0,4'd7,4'd13},{1'b0,4'd4,4'd1,4'd15},
      {1'b1,4'd4,4'd3,4'd13},{1'b1,4'd12,4'd1,4'd7},{1'b0,4'd12,4'd3,4'd5}},
    '{{1'b0,4'd0,4'd5,4'd11},{1'b1,4'd0,4'd7,4'd9},{1'b1,4'd4,4'd1,4'd11},
      {1'b0,4'd4,4'd3,4'd9},{1'b0,4'd8,4'd1,4'd7},{1'b1,4'd8,4'd3,4'd5}},
    '{{1'b0,4'd4,4'd9,4'd14},{1'b1,4'd4,4'd10,4'd13},{1'b1,4'd8,4'd5,4'd14},
      {1'b0,4'd8,4'd6,4'd13},{1'b0,4'd12,4'd5,4'd10},{1'b1,4'd12,4'd6,4'd9}},
    '{{1'b1,4'd0,4'd9,4'd14},{1'b0,4'd0,4'd10,4'd13},{1'b0,4'd8,4'd1,4'd14},
      {1'b1,4'd8,4'd2,4'd13},{1'b1,4'd12,4'd1,4'd10},{1'b0,4'd12,4'd2,4'd9}},
    '{{1'b0,4'd0,4'd5,4'd14},{1'b1,4'd0,4'd6,4'd13},{1'b1,4'd4,4'd1,4'd14},
      {1'b0,4'd4,4'd2,4'd13},{1'b0,4'd12,4'd1,4'd6},{1'b1,4'd12,4'd2,4'd5}},
    '{{1'b1,4'd0,4'd5,4'd10},{1'b0,4'd0,4'd6,4'd9},{1'b0,4'd4,4'd1,4'd10},
      {1'b1,4'd4,4'd2,4'd9},{1'b1,4'd8,4'd1,4'd6},{1'b0,4'd8,4'd2,4'd5}}
  };

endpackage

FILE: design/matrix4_inverse_core.sv
// Sequence: 16 input elements are loaded, then the cofactor products are formed
// (96 terms on a shared shift-add multiplier), then the determinant,
// and a restoring division per inverse element plus output handshake; a singular matrix gives one flagged result.
// Throughput: one matrix at a time; input is held off from the 16th element to the last result.
// Reset: rst_ni asynchronous, active low; clears state, fill count and index/step counters, memories are not cleared.
module matrix4_inverse_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [m4inv_pkg::EW-1:0] s_axis_tdata,  // element[31:0]
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [m4inv_pkg::TDW-1:0] m_axis_tdata, // value[31:0], position[35:32], zero pad
  output logic [m4inv_pkg::TUW-1:0] m_axis_tuser, // singular[0], clipped[1]
  output logic                    m_axis_tlast
);
  import m4inv_pkg::*;

  logic [EW-1:0]   mem [MATRIX_ENTRIES];
  logic [COFW-1:0] cmem [MATRIX_ENTRIES];
  logic [EW-1:0]   rdata_q;
  logic [COFW-1:0] crdata_q;
  logic [AW-1:0]   raddr, craddr;
  logic            we, cwe;

  state_e state_q, state_d;
  logic [AW-1:0]   fill_q, fill_d, idx_q, idx_d;
  logic [2:0]      ti_q, ti_d;
  logic [4:0]      mcnt_q, mcnt_d;
  logic [NCW-1:0]  dcnt_q, dcnt_d;
  logic [MW-1:0]   x_q, x_d, acc_q, acc_d;
  logic [EW-1:0]   y_q, y_d;
  logic [COFW-1:0] cof_q, cof_d;
  logic [DETW-1:0] det_q, det_d;
  logic [NUMW-1:0] num_q, num_d, quo_q, quo_d;
  logic [DMW:0]    rem_q, rem_d;
  logic [DMW-1:0]  dmag_q, dmag_d;
  logic            qneg_q, qneg_d;
  logic [EW-1:0]   oval_q, oval_d;
  logic [AW-1:0]   opos_q, opos_d;
  logic            osing_q, osing_d, oclip_q, oclip_d, olast_q, olast_d;

  logic [12:0]     term;
  logic [MW-1:0]   addend, mul_next;
  logic [DMW:0]    rem_sh;
  logic [COFW-1:0] cneg;
  logic [DETW-1:0] dneg;
  logic [COFW-1:0] cof_sum;
  logic            big;

  always_ff @(posedge clk_i) begin
    if (we) mem[fill_q] <= s_axis_tdata;
    if (cwe) cmem[idx_q] <= cof_sum;
    rdata_q  <= mem[raddr];
    crdata_q <= cmem[craddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      idx_q   <= '0;
      ti_q    <= '0;
      mcnt_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      ti_q    <= ti_d;
      mcnt_q  <= mcnt_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; acc_q <= acc_d; cof_q <= cof_d; det_q <= det_d;
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; dmag_q <= dmag_d; qneg_q <= qneg_d;
    oval_q <= oval_d; opos_q <= opos_d; osing_q <= osing_d; oclip_q <= oclip_d;
    olast_q <= olast_d;
  end

  assign term     = COF_TERMS[idx_q][ti_q];
  assign addend   = y_q[0] ? x_q : '0;
  assign mul_next = (mcnt_q == 5'd31) ? acc_q - addend : acc_q + addend;
  assign rem_sh   = {rem_q[DMW-1:0], num_q[NUMW-1]};
  assign cneg     = -crdata_q;
  assign dneg     = -det_q;
  assign cof_sum  = term[12] ? cof_q + mul_next[COFW-1:0] : cof_q - mul_next[COFW-1:0];

  always_comb begin
    state_d = state_q; fill_d = fill_q; idx_d = idx_q; ti_d = ti_q;
    mcnt_d = mcnt_q; dcnt_d = dcnt_q;
    x_d = x_q; y_d = y_q; acc_d = acc_q; cof_d = cof_q; det_d = det_q;
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; dmag_d = dmag_q; qneg_d = qneg_q;
    oval_d = oval_q; opos_d = opos_q; osing_d = osing_q; oclip_d = oclip_q;
    olast_d = olast_q;
    raddr = term[3:0]; craddr = idx_q; we = 1'b0; cwe = 1'b0; big = 1'b0;
    s_axis_tready = 1'b0; m_axis_tvalid = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          we = 1'b1;
          fill_d = fill_q + 1'b1;
          if (fill_q == AW'(MATRIX_ENTRIES - 1)) begin
            idx_d = '0; ti_d = '0; cof_d = '0; state_d = ST_TA;
          end
        end
      end
      ST_TA: begin
        raddr = term[11:8];
        state_d = ST_TB;
      end
      ST_TB: begin
        raddr = term[7:4];
        x_d = {{(MW-EW){rdata_q[EW-1]}}, rdata_q};
        state_d = ST_TY;
      end
      ST_TY: begin
        y_d = rdata_q; acc_d = '0; mcnt_d = '0;
        state_d = ST_MUL1;
      end
      ST_MUL1, ST_MUL2, ST_MUL3: begin
        acc_d = mul_next; x_d = x_q << 1; y_d = y_q >> 1; mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == 5'd31) begin
          unique case (state_q)
            ST_MUL1: begin
              x_d = mul_next; y_d = rdata_q; acc_d = '0; state_d = ST_MUL2;
            end
            ST_MUL2: begin
              cof_d = cof_sum;
              ti_d = ti_q + 1'b1;
              state_d = ST_TA;
              if (ti_q == 3'd5) begin
                cwe = 1'b1; ti_d = '0; idx_d = idx_q + 1'b1;
                if (idx_q == AW'(MATRIX_ENTRIES - 1)) begin
                  idx_d = '0; det_d = '0; state_d = ST_DA;
                end else begin
                  cof_d = '0;
                end
              end
            end
            default: begin
              det_d = det_q + mul_next;
              idx_d = idx_q + 1'b1;
              state_d = (idx_q == AW'(3)) ? ST_CHK : ST_DA;
            end
          endcase
        end
      end
      ST_DA: begin
        raddr = idx_q; craddr = {idx_q[1:0], 2'b00};
        state_d = ST_DB;
      end
      ST_DB: begin
        x_d = {{(MW-COFW){crdata_q[COFW-1]}}, crdata_q};
        y_d = rdata_q; acc_d = '0; mcnt_d = '0;
        state_d = ST_MUL3;
      end
      ST_CHK: begin
        idx_d = '0;
        dmag_d = det_q[DETW-1] ? dneg[DMW-1:0] : det_q[DMW-1:0];
        if (det_q == '0) begin
          oval_d = '0; opos_d = '0; osing_d = 1'b1; oclip_d = 1'b0; olast_d = 1'b1;
          state_d = ST_OUT;
        end else begin
          state_d = ST_VA;
        end
      end
      ST_VA: state_d = ST_VB;
      ST_VB: begin
        num_d = {(crdata_q[COFW-1] ? cneg[COFW-2:0] : crdata_q[COFW-2:0]),
                 {(2*FRAC_BITS){1'b0}}};
        qneg_d = crdata_q[COFW-1] ^ det_q[DETW-1];
        rem_d = '0; quo_d = '0; dcnt_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        num_d = num_q << 1;
        dcnt_d = dcnt_q + 1'b1;
        if (rem_sh >= {1'b0, dmag_q}) begin
          rem_d = rem_sh - {1'b0, dmag_q};
          quo_d = {quo_q[NUMW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[NUMW-2:0], 1'b0};
        end
        if (dcnt_q == NCW'(NUMW - 1)) begin
          big = |quo_d[NUMW-1:EW];
          if (qneg_q) begin
            if (big || quo_d[EW-1:0] > 32'h8000_0000) begin
              oval_d = 32'h8000_0000; big = 1'b1;
            end else begin
              oval_d = -quo_d[EW-1:0];
            end
          end else begin
            if (big || quo_d[EW-1]) begin
              oval_d = 32'h7FFF_FFFF; big = 1'b1;
            end else begin
              oval_d = quo_d[EW-1:0];
            end
          end
          opos_d = idx_q; osing_d = 1'b0; oclip_d = big;
          olast_d = (idx_q == AW'(MATRIX_ENTRIES - 1));
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (olast_q) begin
            state_d = ST_LOAD;
          end else begin
            idx_d = idx_q + 1'b1; state_d = ST_VA;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign m_axis_tdata = {{(TDW-EW-AW){1'b0}}, opos_q, oval_q};
  assign m_axis_tuser = {oclip_q, osing_q};
  assign m_axis_tlast = olast_q;

endmodule

FILE: design/m4inv_checker.sv
module m4inv_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [m4inv_pkg::TDW-1:0] m_axis_tdata,
  input logic [m4inv_pkg::TUW-1:0] m_axis_tuser,
  input logic                      m_axis_tlast
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input ready while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_sing_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == '0
    && !m_axis_tuser[1]) else $error("bad singular result");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser[0] |-> m_axis_tdata[35:32] == 4'd15)
    else $error("last result not at position 15");
endmodule

bind matrix4_inverse_core m4inv_checker u_m4inv_checker (.*);
